// ===== design/sacr_pkg.sv =====
// sacr_pkg: constants, types and helpers for the cache tag store
// no dependencies
`timescale 1ns / 1ps
package sacr_pkg;
  localparam int SETS = 1024;
  localparam int WAYS = 8;
  localparam int ADDR_BITS = 40;
  localparam int LEADER_SETS = 32;
  localparam int SET_BITS = $clog2(SETS);
  localparam int WAY_BITS = $clog2(WAYS);
  localparam int STRIDE = SETS / LEADER_SETS;
  localparam int STRIDE_BITS = $clog2(STRIDE);
  localparam int LINE_BITS = SET_BITS + WAY_BITS;
  // tag, dirty, owner, rrpv, stamp
  localparam int ENTRY_BITS = ADDR_BITS + 1 + 3 + 3 + 32;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0, ACT_PROBE = 2'd1, ACT_INVAL = 2'd2, ACT_INSTALL = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    POL_LRU = 3'd0, POL_RANDOM = 3'd1, POL_SRRIP = 3'd2, POL_BRRIP = 3'd3,
    POL_DRRIP = 3'd4, POL_FIFO = 3'd5, POL_DIP = 3'd6, POL_RSVD = 3'd7
  } policy_t;

  typedef enum logic [1:0] {
    ST_MISS = 2'd0, ST_HIT = 2'd1, ST_DUP = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SCAN, S_AGE, S_WRITE, S_DONE
  } state_t;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_META_AWARE = 2'd1;
  localparam logic [1:0] REG_META_PRIO = 2'd2;
  localparam logic [1:0] REG_SEED = 2'd3;

  typedef struct packed {
    logic [ADDR_BITS-1:0] tag;
    logic dirty;
    logic [2:0] owner;
    logic [2:0] rrpv;
    logic [31:0] stamp;
  } entry_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    lfsr_step = v[0] ? ((v >> 1) ^ 16'hB400) : (v >> 1);
  endfunction

  // value mod 100 below 5, with a reciprocal multiply
  function automatic logic rare(input logic [15:0] v);
    logic [31:0] q;
    logic [31:0] r;
    q = (32'(v) * 32'd5243) >> 19;
    r = 32'(v) - q * 32'd100;
    if (r >= 32'd100) r = r - 32'd100;
    rare = r < 32'd5;
  endfunction
endpackage

// ===== design/sacr_ram.sv =====
// sacr_ram: generic single-port RAM with registered read
// no dependencies
`timescale 1ns / 1ps
module sacr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== design/set_assoc_cache_replacement.sv =====
// set_assoc_cache_replacement: top level of the cache tag store
// depends on sacr_pkg and sacr_ram
`timescale 1ns / 1ps
// channel  | signals                                         | dir
// request  | in_valid in_stall action line_addr dirty ...    | in
// result   | out_valid out_stall status way set_index victim_* | out
// config   | psel penable pwrite paddr pwdata prdata pready  | in/out
// an item walks the ways one per cycle through one compare unit;
// a new item is accepted only once the last result is taken, and an
// install lowers the set way by way when rrip aging is needed
// after reset a clearing pass over every entry zeroes the memories;
// no item is accepted meanwhile. out_stall holds the result and the block.
module set_assoc_cache_replacement
  import sacr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] action,
  input  logic [ADDR_BITS-1:0] line_addr,
  input  logic dirty,
  input  logic [2:0] thread_id,
  input  logic is_metadata,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [2:0] way,
  output logic [9:0] set_index,
  output logic victim_valid,
  output logic victim_dirty,
  output logic [ADDR_BITS-1:0] victim_tag,
  output logic [2:0] victim_thread,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [2:0] policy;
  logic meta_aware;
  logic [2:0] meta_prio;
  logic [15:0] seed;
  logic [15:0] lfsr;
  logic [9:0] duel;
  logic [31:0] acc;

  state_t state, state_next;
  logic clearing;
  logic [LINE_BITS:0] clr_cnt;
  logic [1:0] r_act;
  logic [ADDR_BITS-1:0] r_addr;
  logic r_dirty, r_meta;
  logic [2:0] r_tid;
  logic [WAY_BITS:0] wi;   // way being read
  logic rd_pend;
  logic [WAY_BITS-1:0] rd_way;
  logic [WAYS-1:0] vbits;
  logic found;
  logic [WAY_BITS-1:0] hit_way;
  logic [WAY_BITS-1:0] min_way;
  logic [2:0] min_rrpv;
  logic [31:0] min_stamp;
  logic age_phase;
  logic [WAY_BITS-1:0] fifo_val;

  logic [SET_BITS-1:0] set;
  assign set = r_addr[SET_BITS-1:0];

  // entry memory, valid bits and fifo pointers
  logic e_we;
  logic [LINE_BITS-1:0] e_addr;
  entry_t e_wdata, e_rdata;
  logic v_we, v_wdata;
  logic [WAYS-1:0] v_rdata;
  logic [WAYS-1:0] v_wmask;
  logic f_we;
  logic [WAY_BITS-1:0] f_wdata, f_rdata;
  logic [SET_BITS-1:0] s_addr;

  sacr_ram #(.WIDTH(ENTRY_BITS), .DEPTH(SETS*WAYS)) u_entry (
    .clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata));
  sacr_ram #(.WIDTH(WAYS), .DEPTH(SETS)) u_valid (
    .clk(clk), .we(v_we), .addr(s_addr),
    .wdata(clearing ? '0 : (v_wdata ? (vbits | v_wmask) : (vbits & ~v_wmask))),
    .rdata(v_rdata));
  sacr_ram #(.WIDTH(WAY_BITS), .DEPTH(SETS)) u_fifo (
    .clk(clk), .we(f_we), .addr(s_addr), .wdata(f_wdata), .rdata(f_rdata));

  // write-back decisions
  logic [WAY_BITS-1:0] tgt;
  logic inval_found;
  logic leader_b, leader_s, use_s;
  logic [15:0] l1;
  logic draw_rand, draw_rare;
  logic [2:0] ins_rrpv;
  logic ins_stamp;
  logic all_valid;
  logic [WAY_BITS-1:0] first_inv;

  always_comb begin
    first_inv = '0;
    inval_found = 1'b0;
    for (int i = WAYS-1; i >= 0; i--)
      if (!vbits[i]) begin
        first_inv = WAY_BITS'(i);
        inval_found = 1'b1;
      end
  end
  assign all_valid = !inval_found;

  assign leader_b = (set >> STRIDE_BITS) < LEADER_SETS &&
                    set[STRIDE_BITS-1:0] == '0;
  assign leader_s = (set >> STRIDE_BITS) < LEADER_SETS &&
                    set[STRIDE_BITS-1:0] == '1;
  assign use_s = leader_s || (!leader_b && duel >= 10'd512);
  assign l1 = lfsr_step(lfsr);
  assign draw_rand = all_valid && policy == POL_RANDOM;
  logic [15:0] l2;
  assign l2 = draw_rand ? lfsr_step(l1) : l1;
  logic [15:0] lr;
  assign lr = draw_rand ? l2 : l1;
  assign draw_rare = policy == POL_BRRIP ||
                     ((policy == POL_DRRIP || policy == POL_DIP) && !use_s);

  always_comb begin
    if (!all_valid) tgt = first_inv;
    else begin
      case (policy)
        POL_RANDOM: tgt = l1[WAY_BITS-1:0];
        POL_SRRIP, POL_BRRIP, POL_DRRIP: tgt = min_way;
        POL_FIFO: tgt = fifo_val;
        default: tgt = min_way;
      endcase
    end
    ins_rrpv = 3'd1;
    ins_stamp = 1'b1;
    if (policy == POL_BRRIP || (policy == POL_DRRIP && !use_s))
      ins_rrpv = rare(lr) ? 3'd1 : 3'd0;
    if (policy == POL_DIP && !use_s) ins_stamp = rare(lr);
    if (meta_aware && r_meta) ins_rrpv = meta_prio;
  end

  logic is_rrip;
  assign is_rrip = policy == POL_SRRIP || policy == POL_BRRIP || policy == POL_DRRIP;

  // victim capture
  entry_t vic;
  logic [WAY_BITS:0] wb_i;   // write sub-step

  // aging subtract runs way by way during write phase
  entry_t aged;
  always_comb begin
    aged = e_rdata;
    aged.rrpv = e_rdata.rrpv - min_rrpv;
  end

  always_comb begin
    state_next = state;
    e_we = 1'b0; e_addr = {set, wi[WAY_BITS-1:0]}; e_wdata = e_rdata;
    v_we = 1'b0; v_wdata = 1'b0; v_wmask = '0;
    f_we = 1'b0; f_wdata = f_rdata;
    s_addr = clearing ? clr_cnt[SET_BITS-1:0] : set;
    if (clearing) begin
      e_we = 1'b1; e_addr = clr_cnt[LINE_BITS-1:0]; e_wdata = '0;
      v_we = clr_cnt[WAY_BITS-1:0] == '0 ? 1'b1 : 1'b0;
      s_addr = clr_cnt[LINE_BITS-1:WAY_BITS];
      f_we = v_we; f_wdata = '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state_next = S_READ;
        S_READ: state_next = S_SCAN;
        S_SCAN: if (!rd_pend && wi == (WAY_BITS+1)'(WAYS)) begin
          state_next = S_WRITE;
          e_addr = {set, (found ? hit_way : tgt)};
        end
        S_WRITE: begin
          e_addr = {set, (found ? hit_way : tgt)};
          if (wb_i == '0) state_next = S_WRITE;
          else if (r_act == ACT_LOOKUP && found) begin
            e_we = 1'b1;
            e_wdata = vic;
            e_wdata.stamp = acc;
            e_wdata.rrpv = 3'd7;
            if (r_dirty) begin e_wdata.dirty = 1'b1; e_wdata.owner = r_tid; end
            state_next = S_DONE;
          end else if (r_act == ACT_INVAL && found) begin
            v_we = 1'b1; v_wmask = WAYS'(1) << hit_way;
            state_next = S_DONE;
          end else if (r_act == ACT_INSTALL && !found) begin
            if (age_phase && is_rrip && all_valid) begin
              // read a way, then write it back lowered on the next cycle
              e_addr = {set, wi[WAY_BITS-1:0]};
              e_we = rd_pend;
              e_wdata = aged;
              state_next = S_WRITE;
            end else begin
              e_we = 1'b1;
              e_wdata.tag = r_addr; e_wdata.dirty = r_dirty;
              e_wdata.owner = r_tid; e_wdata.rrpv = ins_rrpv;
              e_wdata.stamp = ins_stamp ? acc : vic.stamp;
              v_we = 1'b1; v_wdata = 1'b1; v_wmask = WAYS'(1) << tgt;
              f_we = 1'b1; f_wdata = f_rdata + WAY_BITS'(1);
              state_next = S_DONE;
            end
          end else state_next = S_DONE;
        end
        S_DONE: if (!out_stall) state_next = S_IDLE;
        default: state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      clearing <= 1'b1;
      clr_cnt <= '0;
      policy <= POL_LRU; meta_aware <= 1'b0; meta_prio <= 3'd1; seed <= 16'd1;
      lfsr <= 16'd1; duel <= 10'd512; acc <= '0;
      out_valid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + (LINE_BITS+1)'(1);
        if (clr_cnt == (LINE_BITS+1)'(SETS*WAYS-1)) clearing <= 1'b0;
      end
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_POLICY: policy <= pwdata[2:0];
          REG_META_AWARE: meta_aware <= pwdata[0];
          REG_META_PRIO: meta_prio <= pwdata[2:0];
          REG_SEED: begin
            seed <= pwdata[15:0];
            lfsr <= pwdata[15:0] == '0 ? 16'd1 : pwdata[15:0];
          end
          default: ;
        endcase
      end
      if (!clearing) begin
        case (state)
          S_IDLE: if (in_valid) begin
            r_act <= action; r_addr <= line_addr; r_dirty <= dirty;
            r_tid <= thread_id; r_meta <= is_metadata;
            wi <= '0; rd_pend <= 1'b0; found <= 1'b0; hit_way <= '0;
            min_way <= '0; min_rrpv <= 3'd7; min_stamp <= '1;
            age_phase <= 1'b0; wb_i <= '0;
          end
          S_READ: begin
            wi <= wi + (WAY_BITS+1)'(1); rd_pend <= 1'b1; rd_way <= '0;
          end
          S_SCAN: begin
            vbits <= v_rdata;
            fifo_val <= f_rdata;
            if (rd_pend) begin
              if (v_rdata[rd_way] && e_rdata.tag == r_addr && !found) begin
                found <= 1'b1; hit_way <= rd_way;
              end
              if (rd_way == '0 || (is_rrip ? e_rdata.rrpv < min_rrpv
                                   : e_rdata.stamp < min_stamp)) begin
                min_way <= rd_way; min_rrpv <= e_rdata.rrpv;
                min_stamp <= e_rdata.stamp;
              end
            end
            if (wi != (WAY_BITS+1)'(WAYS)) begin
              rd_way <= wi[WAY_BITS-1:0]; wi <= wi + (WAY_BITS+1)'(1);
              rd_pend <= 1'b1;
            end else rd_pend <= 1'b0;
          end
          S_WRITE: begin
            if (wb_i == '0) begin
              wb_i <= (WAY_BITS+1)'(1);
              if (r_act == ACT_INSTALL && !found && is_rrip && all_valid
                  && min_rrpv != 3'd0) begin
                age_phase <= 1'b1; wi <= '0; rd_pend <= 1'b0;
              end
            end else if (age_phase && r_act == ACT_INSTALL && !found) begin
              if (!rd_pend) rd_pend <= 1'b1;
              else begin
                rd_pend <= 1'b0;
                if (wi == (WAY_BITS+1)'(WAYS-1)) age_phase <= 1'b0;
                else wi <= wi + (WAY_BITS+1)'(1);
              end
            end
          end
          default: ;
        endcase
        if (state == S_READ && r_act == ACT_LOOKUP) acc <= acc + 32'd1;
        if (state == S_WRITE && state_next == S_DONE) begin
          out_valid <= 1'b1;
          status <= ST_MISS; way <= '0; set_index <= 10'(set);
          victim_valid <= 1'b0; victim_dirty <= 1'b0; victim_tag <= '0;
          victim_thread <= '0;
          if (r_act != ACT_INSTALL) begin
            status <= found ? ST_HIT : ST_MISS;
            way <= found ? 3'(hit_way) : 3'd0;
          end else if (found) begin
            status <= ST_DUP; way <= 3'(hit_way);
          end else begin
            way <= 3'(tgt);
            if (vbits[tgt]) begin
              victim_valid <= 1'b1; victim_dirty <= vic.dirty;
              victim_tag <= vic.tag; victim_thread <= vic.owner;
            end
            if (draw_rand || draw_rare) lfsr <= draw_rare ? lr : l1;
            if ((policy == POL_DRRIP || policy == POL_DIP) && leader_b
                && duel != 10'd1023) duel <= duel + 10'd1;
            if ((policy == POL_DRRIP || policy == POL_DIP) && leader_s
                && duel != 10'd0) duel <= duel - 10'd1;
          end
        end
        if (state == S_DONE && !out_stall) out_valid <= 1'b0;
      end
    end
  end

  // hold the targeted entry for the write phase
  always_ff @(posedge clk) begin
    if (state == S_WRITE && wb_i == '0) vic <= e_rdata;
  end

  assign in_stall = clearing || state != S_IDLE;
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_POLICY: prdata = {29'd0, policy};
      REG_META_AWARE: prdata = {31'd0, meta_aware};
      REG_META_PRIO: prdata = {29'd0, meta_prio};
      default: prdata = {16'd0, seed};
    endcase
  end

`ifndef SYNTHESIS
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_DONE) else $error("result outside done state");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall) else $error("accepted during clearing");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("result dropped under stall");
`endif
endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for the set-associative cache tag store
// depends on sacr_pkg and set_assoc_cache_replacement; the expected results
// come from a cycle-free model of the tag store, lru/rrip/fifo/dip state
`timescale 1ns / 1ps
module tb_top;
  import sacr_pkg::*;

  localparam int LIMIT = 1500000;
  localparam int NLINES = SETS * WAYS;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] way;
    logic [9:0] set_index;
    logic victim_valid;
    logic victim_dirty;
    logic [ADDR_BITS-1:0] victim_tag;
    logic [2:0] victim_thread;
  } lookup_res_t;

  typedef struct {
    action_t act;
    logic [ADDR_BITS-1:0] addr;
    logic d;
    logic [2:0] tid;
    logic meta;
    bit typed;
    status_t st;
    logic [2:0] w;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = ACT_PROBE;
  logic [ADDR_BITS-1:0] line_addr = '0;
  logic dirty = 1'b0;
  logic [2:0] thread_id = '0;
  logic is_metadata = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [2:0] way;
  logic [9:0] set_index;
  logic victim_valid;
  logic victim_dirty;
  logic [ADDR_BITS-1:0] victim_tag;
  logic [2:0] victim_thread;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  set_assoc_cache_replacement i_dut (.*);

  always #5 clk = ~clk;

  // model copy of the tag store
  bit m_valid [NLINES];
  bit m_dirty [NLINES];
  logic [ADDR_BITS-1:0] m_tag [NLINES];
  bit [2:0] m_rrpv [NLINES];
  bit [31:0] m_stamp [NLINES];
  bit [2:0] m_owner [NLINES];
  bit [2:0] m_fifo [SETS];
  int unsigned m_duel = 512;
  bit [31:0] m_access = 0;
  bit [15:0] m_lfsr = 16'd1;
  policy_t cfg_policy = POL_LRU;
  bit cfg_aware = 0;
  bit [2:0] cfg_prio = 3'd1;

  lookup_res_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_results = 0;
  int n_evictions = 0;
  int send_idle = 0;
  int recv_idle = 0;
  logic [ADDR_BITS-1:0] addr_pool[40];

  function automatic bit [15:0] next_rand();
    m_lfsr = m_lfsr[0] ? ((m_lfsr >> 1) ^ 16'hB400) : (m_lfsr >> 1);
    return m_lfsr;
  endfunction

  function automatic bit rare_draw();
    return (next_rand() % 100) < 5;
  endfunction

  // true when the duel picks the srrip/lru side
  function automatic bit duel_pick(int unsigned set);
    int unsigned pos;
    pos = set % STRIDE;
    if ((set / STRIDE) < LEADER_SETS && pos == 0) begin
      if (m_duel < 1023) m_duel++;
      return 0;
    end
    if ((set / STRIDE) < LEADER_SETS && pos == STRIDE - 1) begin
      if (m_duel > 0) m_duel--;
      return 1;
    end
    return m_duel >= 512;
  endfunction

  function automatic lookup_res_t predict_access(action_t act, logic [ADDR_BITS-1:0] addr,
                                                 bit d, bit [2:0] tid, bit meta);
    lookup_res_t r;
    int unsigned set, base, vic, i;
    int hit_way;
    bit [2:0] rr, mn;
    bit stamp_it;
    r = '0;
    set = addr % SETS;
    base = set * WAYS;
    hit_way = -1;
    r.set_index = set[9:0];
    for (int w = 0; w < WAYS; w++)
      if (hit_way < 0 && m_valid[base+w] && m_tag[base+w] == addr) hit_way = w;
    if (act == ACT_LOOKUP) begin
      m_access++;
      if (hit_way >= 0) begin
        m_stamp[base+hit_way] = m_access;
        m_rrpv[base+hit_way] = 3'd7;
        if (d) begin
          m_dirty[base+hit_way] = 1;
          m_owner[base+hit_way] = tid;
        end
      end
    end else if (act == ACT_INVAL && hit_way >= 0) begin
      m_valid[base+hit_way] = 0;
    end
    if (act != ACT_INSTALL) begin
      r.status = (hit_way >= 0) ? ST_HIT : ST_MISS;
      r.way = (hit_way >= 0) ? hit_way[2:0] : 3'd0;
      return r;
    end
    if (hit_way >= 0) begin
      r.status = ST_DUP;
      r.way = hit_way[2:0];
      return r;
    end
    vic = WAYS;
    for (int w = 0; w < WAYS; w++)
      if (vic == WAYS && !m_valid[base+w]) vic = w;
    if (vic == WAYS) begin
      case (cfg_policy)
        POL_RANDOM: vic = next_rand() % WAYS;
        POL_SRRIP, POL_BRRIP, POL_DRRIP: begin
          vic = 0;
          mn = m_rrpv[base];
          for (int w = 1; w < WAYS; w++)
            if (m_rrpv[base+w] < mn) begin
              mn = m_rrpv[base+w];
              vic = w;
            end
          for (int w = 0; w < WAYS; w++) m_rrpv[base+w] -= mn;
        end
        POL_FIFO: vic = m_fifo[set];
        default: begin
          vic = 0;
          for (int w = 1; w < WAYS; w++)
            if (m_stamp[base+w] < m_stamp[base+vic]) vic = w;
        end
      endcase
    end
    i = base + vic;
    if (m_valid[i]) begin
      r.victim_valid = 1;
      r.victim_dirty = m_dirty[i];
      r.victim_tag = m_tag[i];
      r.victim_thread = m_owner[i];
      n_evictions++;
    end
    rr = 3'd1;
    stamp_it = 1;
    if (cfg_policy == POL_BRRIP) rr = rare_draw() ? 3'd1 : 3'd0;
    else if (cfg_policy == POL_DRRIP) begin
      if (!duel_pick(set)) rr = rare_draw() ? 3'd1 : 3'd0;
    end else if (cfg_policy == POL_DIP) begin
      if (!duel_pick(set)) stamp_it = rare_draw();
    end
    if (cfg_aware && meta) rr = cfg_prio;
    m_tag[i] = addr;
    m_valid[i] = 1;
    m_owner[i] = tid;
    m_dirty[i] = d;
    m_rrpv[i] = rr;
    if (stamp_it) m_stamp[i] = m_access;
    m_fifo[set] = m_fifo[set] + 3'd1;
    r.status = ST_MISS;
    r.way = vic[2:0];
    return r;
  endfunction

  // receiver side
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    lookup_res_t got, want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[set_assoc_cache_replacement] ERROR");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      got = '{status, way, set_index, victim_valid, victim_dirty, victim_tag,
              victim_thread};
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic send_item(action_t a, logic [ADDR_BITS-1:0] addr, bit d, bit [2:0] tid,
                           bit meta, bit typed = 0, status_t st = ST_MISS,
                           logic [2:0] w = 0);
    lookup_res_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action = a;
    line_addr = addr;
    dirty = d;
    thread_id = tid;
    is_metadata = meta;
    do @(posedge clk); while (in_stall);
    r = predict_access(a, addr, d, tid, meta);
    if (typed && (r.status !== st || r.way !== w)) begin
      errors++;
      if (errors <= 10) $display("table row: expected %0d/%0d, model gives %0d/%0d",
                                 st, w, r.status, r.way);
      r.status = st;
      r.way = w;
    end
    pending_results.push_back(r);
    n_items++;
    @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_POLICY: cfg_policy = policy_t'(val[2:0]);
      REG_META_AWARE: cfg_aware = val[0];
      REG_META_PRIO: cfg_prio = val[2:0];
      default: m_lfsr = (val[15:0] == 0) ? 16'd1 : val[15:0];
    endcase
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  localparam logic [ADDR_BITS-1:0] AMAX = {ADDR_BITS{1'b1}};
  dir_row_t dir_rows[] = '{
    '{ACT_PROBE, '0, 0, 0, 0, 1, ST_MISS, 0},
    '{ACT_LOOKUP, AMAX, 1, 7, 1, 1, ST_MISS, 0},
    '{ACT_INSTALL, AMAX, 1, 7, 1, 1, ST_MISS, 0},
    '{ACT_INSTALL, AMAX, 0, 0, 0, 1, ST_DUP, 0},
    '{ACT_PROBE, AMAX, 0, 0, 0, 1, ST_HIT, 0},
    '{ACT_LOOKUP, AMAX, 1, 5, 0, 1, ST_HIT, 0},
    '{ACT_INSTALL, 40'h3FF, 0, 3, 0, 1, ST_MISS, 1},
    '{ACT_INVAL, AMAX, 0, 0, 0, 1, ST_HIT, 0},
    '{ACT_INVAL, AMAX, 0, 0, 0, 1, ST_MISS, 0},
    '{ACT_LOOKUP, AMAX, 0, 0, 0, 1, ST_MISS, 0},
    '{ACT_INSTALL, '0, 1, 7, 1, 1, ST_MISS, 0},
    '{ACT_INSTALL, 40'h400, 0, 1, 0, 0, ST_MISS, 0},
    '{ACT_INSTALL, 40'h800, 1, 2, 0, 0, ST_MISS, 0},
    '{ACT_INSTALL, 40'hC00, 0, 4, 1, 0, ST_MISS, 0},
    '{ACT_INSTALL, 40'h1000, 1, 6, 0, 0, ST_MISS, 0},
    '{ACT_INSTALL, 40'h1400, 0, 0, 0, 0, ST_MISS, 0},
    '{ACT_INSTALL, 40'h1800, 1, 7, 0, 0, ST_MISS, 0},
    '{ACT_INSTALL, 40'h1C00, 0, 3, 0, 0, ST_MISS, 0},
    '{ACT_LOOKUP, 40'h400, 1, 6, 0, 0, ST_MISS, 0},
    '{ACT_INSTALL, 40'h2000, 0, 5, 1, 0, ST_MISS, 0},
    '{ACT_INSTALL, AMAX ^ 40'h400, 1, 7, 1, 0, ST_MISS, 0},
    '{ACT_PROBE, 40'h800, 0, 0, 0, 0, ST_MISS, 0}
  };

  int unsigned set_choice[6] = '{0, 31, 1023, 37, 64, 95};
  int unsigned phase_policy[9] = '{0, 1, 2, 3, 4, 5, 6, 7, 4};

  initial begin
    int unsigned pick;
    action_t a;
    logic [ADDR_BITS-1:0] addr;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    foreach (dir_rows[k])
      send_item(dir_rows[k].act, dir_rows[k].addr, dir_rows[k].d, dir_rows[k].tid,
                dir_rows[k].meta, dir_rows[k].typed, dir_rows[k].st, dir_rows[k].w);
    for (int p = 0; p < 9; p++) begin
      drain();
      reg_write(REG_POLICY, phase_policy[p]);
      reg_write(REG_META_AWARE, p % 2);
      reg_write(REG_META_PRIO, (p == 3 || p == 7) ? 7 : (p == 2 ? 0 : $urandom_range(7)));
      reg_write(REG_SEED, p == 0 ? 0 : (p == 1 ? 32'hFFFF : $urandom_range(65535)));
      case (p % 3)
        0: begin send_idle = 20; recv_idle = 58; end
        1: begin send_idle = 58; recv_idle = 20; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      foreach (addr_pool[k])
        addr_pool[k] = {(ADDR_BITS-10)'({$urandom, $urandom}),
                        10'(set_choice[$urandom_range(5)])};
      for (int n = 0; n < 190; n++) begin
        pick = $urandom_range(99);
        a = pick < 40 ? ACT_INSTALL : pick < 75 ? ACT_LOOKUP : pick < 85 ? ACT_PROBE
            : ACT_INVAL;
        addr = ($urandom_range(9) == 0) ? ADDR_BITS'({$urandom, $urandom})
               : addr_pool[$urandom_range(39)];
        send_item(a, addr, 1'($urandom_range(1)), 3'($urandom_range(7)),
                  1'($urandom_range(1)));
      end
    end
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("%0d requests, %0d results, %0d evictions over all policies", n_items,
             n_results, n_evictions);
    $display("%0d mismatches in %0d cycles", errors, cycles);
    if (errors == 0 && pending_results.size() == 0)
      $display("[set_assoc_cache_replacement] OK");
    else
      $display("[set_assoc_cache_replacement] ERROR");
    $finish;
  end
endmodule
